// ===== hdl/g128a_pkg.sv =====
// Shared types and constants for the Grain-128a keystream and MAC block.
package g128a_pkg;

  localparam int unsigned TAG_WIDTH = 32;

  localparam logic [31:0] TagMask = 32'((64'd1 << TAG_WIDTH) - 64'd1);

  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_IV_LOW   = 2'd2;
  localparam logic [1:0] CFG_IV_HIGH  = 2'd3;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       first;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0]  keystream_byte;
    logic [31:0] tag;
    logic        tag_valid;
  } out_t;

  typedef struct packed {
    logic [127:0] lfsr;
    logic [127:0] nfsr;
  } cipher_t;

endpackage

// ===== hdl/g128a_round.sv =====
// One Grain-128a clock: pre-output bit and next LFSR and NFSR contents.
module g128a_round
  import g128a_pkg::*;
(
  input  cipher_t st_i,
  input  logic    feedback_i,
  output cipher_t st_o,
  output logic    y_o
);

  logic [127:0] l;
  logic [127:0] n;
  logic         lf;
  logic         nf;
  logic         h;
  logic         y;

  assign l = st_i.lfsr;
  assign n = st_i.nfsr;

  always_comb begin
    lf = l[0] ^ l[7] ^ l[38] ^ l[70] ^ l[81] ^ l[96];
    nf = l[0] ^ n[0] ^ n[26] ^ n[56] ^ n[91] ^ n[96]
       ^ (n[3] & n[67]) ^ (n[11] & n[13]) ^ (n[17] & n[18])
       ^ (n[27] & n[59]) ^ (n[40] & n[48]) ^ (n[61] & n[65])
       ^ (n[68] & n[84]) ^ (n[88] & n[92] & n[93] & n[95])
       ^ (n[22] & n[24] & n[25]) ^ (n[70] & n[78] & n[82]);
    h  = (n[12] & l[8]) ^ (l[13] & l[20]) ^ (n[95] & l[42])
       ^ (l[60] & l[79]) ^ (n[12] & n[95] & l[94]);
    y  = h ^ l[93] ^ n[2] ^ n[15] ^ n[36] ^ n[45] ^ n[64] ^ n[73] ^ n[89];
    if (feedback_i) begin
      lf = lf ^ y;
      nf = nf ^ y;
    end
  end

  assign st_o.lfsr = {lf, l[127:1]};
  assign st_o.nfsr = {nf, n[127:1]};
  assign y_o       = y;

endmodule

// ===== hdl/grain128a_keystream_mac.sv =====
// Grain-128a keystream and MAC: one message byte per transfer.
// Each input transfer yields one result of eight keystream bits (first bit in bit 0)
// and, on a last byte in authentication mode (IV bit 0 set), the tag. The round logic
// advances the cipher by one clock per cycle in the warm-up, fill and byte states, which
// lie between the idle state that takes the transfer and the emit state that posts the
// result; in authentication mode every other keystream bit goes to the MAC. A byte
// flagged first loads key and IV and adds the warm-up, with keystream fed back into
// both registers, and in authentication mode the filling of the accumulator and shift
// register. The input is not ready while a byte is in progress; a result waiting at the
// output does not stop the next transfer from being taken, only from being posted.
module grain128a_keystream_mac
  import g128a_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WARM = 3'd1;
  localparam logic [2:0] S_AUTH = 3'd2;
  localparam logic [2:0] S_BYTE = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [63:0] key_low_q, key_high_q, iv_low_q;
  logic [31:0] iv_high_q;
  cipher_t     st_q, st_d, st_next;
  logic        y;
  logic        auth_q, auth_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] ash_q, ash_d;
  logic [7:0]  ks_q, ks_d;
  logic [7:0]  msg_q, msg_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;
  logic        in_fire;
  logic        cfg_fire;
  logic        slot_free;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  g128a_round u_round (
    .st_i       (st_q),
    .feedback_i (state_q == S_WARM),
    .st_o       (st_next),
    .y_o        (y)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    st_d        = st_q;
    auth_d      = auth_q;
    acc_d       = acc_q;
    ash_d       = ash_q;
    ks_d        = ks_q;
    msg_d       = msg_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          msg_d  = in_data_i.msg_byte;
          last_d = in_data_i.last;
          cnt_d  = '0;
          if (in_data_i.first) begin
            st_d.nfsr = {key_high_q, key_low_q};
            st_d.lfsr = {1'b0, 31'h7FFF_FFFF, iv_high_q, iv_low_q};
            auth_d    = iv_low_q[0];
            acc_d     = '0;
            ash_d     = '0;
            state_d   = S_WARM;
          end else begin
            state_d = S_BYTE;
          end
        end
      end
      S_WARM: begin
        st_d  = st_next;
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == 8'd255) begin
          cnt_d   = '0;
          state_d = auth_q ? S_AUTH : S_BYTE;
        end
      end
      S_AUTH: begin
        st_d  = st_next;
        cnt_d = cnt_q + 8'd1;
        if (cnt_q < 8'd32) begin
          acc_d = {y, acc_q[31:1]};
        end else begin
          ash_d = {y, ash_q[31:1]};
        end
        if (cnt_q == 8'd63) begin
          cnt_d   = '0;
          state_d = S_BYTE;
        end
      end
      S_BYTE: begin
        st_d  = st_next;
        cnt_d = cnt_q + 8'd1;
        if (!auth_q || !cnt_q[0]) begin
          ks_d = {y, ks_q[7:1]};
        end else begin
          if (msg_q[0]) begin
            acc_d = acc_q ^ ash_q;
          end
          ash_d = {y, ash_q[31:1]};
          msg_d = {1'b0, msg_q[7:1]};
        end
        if (cnt_q == (auth_q ? 8'd15 : 8'd7)) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_d.keystream_byte = ks_q;
          out_d.tag_valid      = last_q & auth_q;
          out_d.tag            = (last_q & auth_q) ? (acc_q & TagMask) : '0;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      auth_q      <= 1'b0;
      st_q        <= '0;
      acc_q       <= '0;
      ash_q       <= '0;
      key_low_q   <= '0;
      key_high_q  <= '0;
      iv_low_q    <= '0;
      iv_high_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      auth_q      <= auth_d;
      st_q        <= st_d;
      acc_q       <= acc_d;
      ash_q       <= ash_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
          CFG_KEY_HIGH: key_high_q <= cfg_data_i;
          CFG_IV_LOW:   iv_low_q   <= cfg_data_i;
          CFG_IV_HIGH:  iv_high_q  <= cfg_data_i[31:0];
          default:      iv_high_q  <= iv_high_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ks_q   <= ks_d;
    msg_q  <= msg_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  a_auth_fill_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AUTH) |-> auth_q)
    else $error("authentication fill entered in plain mode");

  a_byte_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTE) |-> (cnt_q <= (auth_q ? 8'd15 : 8'd7)))
    else $error("byte clock count overran");

  a_warm_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WARM && cnt_q == 8'd255) |=> (state_q == S_AUTH || state_q == S_BYTE))
    else $error("warm-up did not end after 256 clocks");

  a_emit_posts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && slot_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not posted on leaving emit");

endmodule

// ===== sim/tb_grain128a_keystream_mac.sv =====
// Testbench for grain128a_keystream_mac: predicts keystream bytes and tags and checks every result.
module tb_grain128a_keystream_mac;
  timeunit 1ns;
  timeprecision 1ps;

  import g128a_pkg::*;

  localparam int unsigned OutTaps [7] = '{2, 15, 36, 45, 64, 73, 89};
  localparam int RandomItems = 2000;
  localparam int LongHold    = 1500;
  localparam int IdleLimit   = 10000;
  localparam int EndCycles   = 400;

  class grain_tracker;
    logic [63:0]  key_lo, key_hi, iv_lo;
    logic [31:0]  iv_hi;
    logic [127:0] lfsr, nfsr;
    logic [31:0]  acc, auth_sr;
    bit           auth;
    out_t         expected_outputs [$];
    int           errors;
    int           outputs_seen;

    function new();
      key_lo = '0;
      key_hi = '0;
      iv_lo = '0;
      iv_hi = '0;
      lfsr = '0;
      nfsr = '0;
      acc = '0;
      auth_sr = '0;
      auth = 1'b0;
      errors = 0;
      outputs_seen = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_KEY_LOW:  key_lo = data;
        CFG_KEY_HIGH: key_hi = data;
        CFG_IV_LOW:   iv_lo = data;
        CFG_IV_HIGH:  iv_hi = data[31:0];
        default: ;
      endcase
    endfunction

    function bit clock_cipher(bit feed);
      bit lf, nf, h, y;
      lf = lfsr[0] ^ lfsr[7] ^ lfsr[38] ^ lfsr[70] ^ lfsr[81] ^ lfsr[96];
      nf = lfsr[0] ^ nfsr[0] ^ nfsr[26] ^ nfsr[56] ^ nfsr[91] ^ nfsr[96]
         ^ (nfsr[3] & nfsr[67]) ^ (nfsr[11] & nfsr[13]) ^ (nfsr[17] & nfsr[18])
         ^ (nfsr[27] & nfsr[59]) ^ (nfsr[40] & nfsr[48]) ^ (nfsr[61] & nfsr[65])
         ^ (nfsr[68] & nfsr[84]) ^ (nfsr[88] & nfsr[92] & nfsr[93] & nfsr[95])
         ^ (nfsr[22] & nfsr[24] & nfsr[25]) ^ (nfsr[70] & nfsr[78] & nfsr[82]);
      h = (nfsr[12] & lfsr[8]) ^ (lfsr[13] & lfsr[20]) ^ (nfsr[95] & lfsr[42])
        ^ (lfsr[60] & lfsr[79]) ^ (nfsr[12] & nfsr[95] & lfsr[94]);
      y = h ^ lfsr[93];
      for (int k = 0; k < 7; k++) y ^= nfsr[OutTaps[k]];
      if (feed) begin
        lf ^= y;
        nf ^= y;
      end
      lfsr = {lf, lfsr[127:1]};
      nfsr = {nf, nfsr[127:1]};
      return y;
    endfunction

    function void load_and_warm_up();
      bit unused;
      nfsr = {key_hi, key_lo};
      lfsr = {1'b0, {31{1'b1}}, iv_hi, iv_lo};
      auth = iv_lo[0];
      acc = '0;
      auth_sr = '0;
      for (int i = 0; i < 256; i++) unused = clock_cipher(1'b1);
      if (auth) begin
        for (int i = 0; i < 32; i++) acc[i] = clock_cipher(1'b0);
        for (int i = 0; i < 32; i++) auth_sr[i] = clock_cipher(1'b0);
      end
    endfunction

    function void note_byte(in_t it);
      out_t exp;
      bit   y;
      if (it.first) load_and_warm_up();
      exp = '0;
      for (int i = 0; i < 8; i++) begin
        exp.keystream_byte[i] = clock_cipher(1'b0);
        if (auth) begin
          y = clock_cipher(1'b0);
          if (it.msg_byte[i]) acc ^= auth_sr;
          auth_sr = {y, auth_sr[31:1]};
        end
      end
      if (it.last && auth) begin
        exp.tag = acc & TagMask;
        exp.tag_valid = 1'b1;
      end
      expected_outputs = {expected_outputs, exp};
    endfunction

    function void check_output(out_t got);
      out_t exp;
      outputs_seen++;
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: keystream_byte %0h tag %0h tag_valid %0b",
               got.keystream_byte, got.tag, got.tag_valid);
        errors++;
        return;
      end
      exp = expected_outputs.pop_front();
      if (got.keystream_byte !== exp.keystream_byte) begin
        $error("keystream_byte: expected %0h, actual %0h", exp.keystream_byte,
               got.keystream_byte);
        errors++;
      end
      if (got.tag !== exp.tag) begin
        $error("tag: expected %0h, actual %0h", exp.tag, got.tag);
        errors++;
      end
      if (got.tag_valid !== exp.tag_valid) begin
        $error("tag_valid: expected %0b, actual %0b", exp.tag_valid, got.tag_valid);
        errors++;
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_KEY_LOW;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;

  grain_tracker tracker = new();
  int           burst_left = 0;

  grain128a_keystream_mac dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_t make_byte(logic [7:0] msg, logic first, logic last);
    in_t it;
    it.msg_byte = msg;
    it.first = first;
    it.last = last;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_byte(input in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
        in_data = in_t'(10'($urandom));
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    tracker.note_byte(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    tracker.note_config(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = rand64();
  endtask

  task automatic load_settings(input logic [63:0] klo, input logic [63:0] khi,
                               input logic [63:0] ivlo, input logic [63:0] ivhi);
    write_reg(CFG_KEY_LOW, klo);
    write_reg(CFG_KEY_HIGH, khi);
    write_reg(CFG_IV_LOW, ivlo);
    write_reg(CFG_IV_HIGH, ivhi);
  endtask

  // receiver: stall pattern plus one long hold-off
  initial begin
    int seg_left;
    int mode;
    bit held;
    seg_left = 0;
    mode = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && rst_n && in_valid && tracker.outputs_seen >= 200) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (LongHold) @(negedge clk);
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
      @(posedge clk);
      if (out_valid && out_ready) tracker.check_output(out_data);
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IdleLimit) begin
        $display("grain128a_keystream_mac test failed");
        $finish;
      end
    end
  end

  initial begin
    int   sent;
    int   len;
    int   kind;
    int   pick;
    logic first;
    logic last;
    logic [63:0] ivlo;
    sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no first after reset: zero state, plain mode
    send_byte(make_byte(8'h00, 1'b0, 1'b0));
    send_byte(make_byte(8'hFF, 1'b0, 1'b0));
    send_byte(make_byte(8'($urandom), 1'b0, 1'b1));
    drain();

    load_settings('1, '1, '1, '1);
    send_byte(make_byte(8'hFF, 1'b1, 1'b1));
    send_byte(make_byte(8'h00, 1'b1, 1'b0));
    send_byte(make_byte(8'hA5, 1'b0, 1'b0));
    send_byte(make_byte(8'h80, 1'b0, 1'b1));
    send_byte(make_byte(8'h3C, 1'b0, 1'b0));
    drain();

    // new settings take effect only on the next first
    load_settings('0, '0, '0, '0);
    send_byte(make_byte(8'h7E, 1'b0, 1'b1));
    send_byte(make_byte(8'hFF, 1'b1, 1'b0));
    send_byte(make_byte(8'h00, 1'b0, 1'b1));
    drain();

    load_settings(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h5555_5555_5555_5555, 64'hFFFF_FFFF_0000_0000);
    send_byte(make_byte(8'h01, 1'b1, 1'b0));
    send_byte(make_byte(8'hFE, 1'b0, 1'b0));
    send_byte(make_byte(8'($urandom), 1'b0, 1'b1));
    send_byte(make_byte(8'($urandom), 1'b1, 1'b1));
    drain();

    load_settings('1, '1, 64'hFFFF_FFFF_FFFF_FFFE, '1);
    send_byte(make_byte(8'hFF, 1'b1, 1'b1));
    send_byte(make_byte(8'h00, 1'b0, 1'b0));
    drain();

    while (sent < RandomItems) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: load_settings('0, '0, '0, '0);
        1: load_settings('1, '1, '1, '1);
        2: load_settings('1, '1, 64'hFFFF_FFFF_FFFF_FFFE, '1);
        default: begin
          ivlo = rand64();
          load_settings(rand64(), rand64(), ivlo, rand64());
        end
      endcase
      repeat ($urandom_range(1, 6)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        kind = $urandom_range(0, 9);
        for (int j = 0; j < len; j++) begin
          first = (j == 0);
          last = (j == len - 1);
          if (kind == 0) begin
            first = ($urandom_range(0, 7) == 0);
            last = 1'($urandom_range(0, 1));
          end else if (kind == 1) begin
            if (j == 0) first = 1'($urandom_range(0, 1));
            if (j == len - 1) last = 1'($urandom_range(0, 1));
          end
          send_byte(make_byte(8'($urandom), first, last));
          sent++;
        end
        if ($urandom_range(0, 14) == 0) drain();
      end
      drain();
    end

    drain();
    repeat (EndCycles) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("grain128a_keystream_mac test passed");
    end else begin
      $display("grain128a_keystream_mac test failed");
    end
    $finish;
  end

endmodule
